[rtl/mcg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_pkg - shared definitions for the metronome click generator
// Register indexes, field widths and the constant meter table (beats per bar
// and accent code of each beat).
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int PERIOD_WIDTH    = 22;
  localparam int METER_WIDTH     = 4;
  localparam int BEAT_WIDTH      = 3;
  localparam int CFG_INDEX_WIDTH = 4;
  localparam int SAMPLE_WIDTH    = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BEAT_PERIOD = 4'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_METER_INDEX = 4'd1;

  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 22'd44100;
  localparam logic [METER_WIDTH-1:0]  METER_RESET  = 4'd0;

  // Positions within the beat where the target changes
  localparam int FLIP_COUNT  = 10;
  localparam int RISE_COUNT  = 25;
  localparam int DECAY_COUNT = 35;

  typedef enum logic [1:0] {
    ACC_ZERO  = 2'd0,
    ACC_FULL  = 2'd1,
    ACC_HALF  = 2'd2,
    ACC_SIXTY = 2'd3
  } accent_t;

  // Beats per bar; unused meter codes act as a single-beat bar
  function automatic logic [BEAT_WIDTH-1:0] meter_beats(input logic [METER_WIDTH-1:0] meter);
    logic [BEAT_WIDTH-1:0] n;
    case (meter)
      4'd0:    n = 3'd1;
      4'd1:    n = 3'd2;
      4'd2:    n = 3'd3;
      4'd3:    n = 3'd4;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd3;
      4'd6:    n = 3'd4;
      4'd7:    n = 3'd6;
      4'd8:    n = 3'd2;
      4'd9:    n = 3'd3;
      4'd10:   n = 3'd4;
      4'd11:   n = 3'd6;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  // Accent of a beat: first beat full, then the row's pattern, zero past the bar
  function automatic accent_t meter_accent(input logic [METER_WIDTH-1:0] meter,
                                           input logic [BEAT_WIDTH-1:0]  beat);
    accent_t a;
    a = ACC_ZERO;
    if (beat == 3'd0) begin
      a = ACC_FULL;
    end else if (beat < meter_beats(meter)) begin
      case (meter)
        4'd3, 4'd6, 4'd10: a = (beat == 3'd2) ? ACC_SIXTY : ACC_HALF;
        4'd7, 4'd11:       a = (beat == 3'd3) ? ACC_SIXTY : ACC_HALF;
        default:           a = ACC_HALF;
      endcase
    end
    return a;
  endfunction

endpackage
`default_nettype wire

[rtl/mcg_div3.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_div3 - unsigned divide by three
// Reciprocal multiply followed by a single correction step.
// ----------------------------------------------------------------------------
module mcg_div3 #(
  parameter int WIDTH = 17
) (
  input  wire logic [WIDTH-1:0] dividend,
  output logic      [WIDTH-1:0] quotient
);

  // floor(2^WIDTH / 3): estimate is exact or one short
  localparam logic [WIDTH-1:0] RECIP = WIDTH'((64'(1) << WIDTH) / 3);

  logic [2*WIDTH-1:0] product;
  logic [WIDTH-1:0]   estimate;
  logic [WIDTH+1:0]   triple;
  logic [WIDTH+1:0]   remainder;

  always_comb begin
    product   = (2*WIDTH)'(dividend) * (2*WIDTH)'(RECIP);
    estimate  = product[2*WIDTH-1:WIDTH];
    triple    = ((WIDTH+2)'(estimate) << 1) + (WIDTH+2)'(estimate);
    remainder = (WIDTH+2)'(dividend) - triple;
    quotient  = (remainder >= (WIDTH+2)'(3)) ? estimate + WIDTH'(1) : estimate;
  end

endmodule
`default_nettype wire

[rtl/metronome_click_generator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// metronome_click_generator_top - metronome click synthesiser
// One click sample per input tick, accents from a constant meter table.
// ----------------------------------------------------------------------------
// Each beat accepted on the slave stream is one audio sample tick; the block
// answers with exactly one beat on the master stream carrying a signed click
// sample and the number of the beat whose accent is sounding. One tick is
// taken every clock cycle and its result appears in the output register on
// the next cycle; the rate is set by the sample recurrence (counter, target
// and the three-tap averaging filter) closing combinationally. The output
// register frees as it is drained, so a held result blocks new ticks only
// while m_tready stays low. Write beat_period (samples per beat, sixty times
// the sample rate over the tempo) and meter_index (bar shape) while the
// stream is idle. Setting restart on a tick clears the counter, beat number
// and filter before that tick is worked.
// ----------------------------------------------------------------------------
module metronome_click_generator_top
  import mcg_pkg::*;
#(
  parameter int COUNT_WIDTH = 22,
  parameter int AMP_WIDTH   = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration write channel
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [PERIOD_WIDTH-1:0]    cfg_data,
  // tick input
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [7:0]                 s_tdata,  // [0] restart, [7:1] zero
  // click output
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [23:0]                     m_tdata   // [15:0] sample, [18:16] beat_number
);

  // Accent levels follow the amplitude width
  localparam int SUM_WIDTH = AMP_WIDTH + 2;
  localparam int MAG_WIDTH = AMP_WIDTH + 1;
  localparam logic signed [AMP_WIDTH-1:0] AMP_FULL =
    AMP_WIDTH'((64'(1) << (AMP_WIDTH - 1)) - 1);
  localparam logic signed [AMP_WIDTH-1:0] AMP_HALF =
    AMP_WIDTH'(((64'(1) << (AMP_WIDTH - 1)) - 1) >> 1);
  localparam logic signed [AMP_WIDTH-1:0] AMP_SIXTY =
    AMP_WIDTH'((((64'(1) << (AMP_WIDTH - 1)) - 1) * 3) / 5);

  // Configuration registers
  logic [PERIOD_WIDTH-1:0] beat_period;
  logic [METER_WIDTH-1:0]  meter_index;

  // Run state
  logic [COUNT_WIDTH-1:0]       sample_count;
  logic [BEAT_WIDTH-1:0]        beat_index;
  logic signed [AMP_WIDTH-1:0]  target_level;
  logic signed [AMP_WIDTH-1:0]  current_out;
  logic signed [AMP_WIDTH-1:0]  previous_out;

  logic [COUNT_WIDTH-1:0]       sample_count_next;
  logic [BEAT_WIDTH-1:0]        beat_index_next;
  logic signed [AMP_WIDTH-1:0]  target_level_next;
  logic signed [AMP_WIDTH-1:0]  result;

  // Step datapath
  logic                         tick;
  logic                         restart;
  logic [COUNT_WIDTH-1:0]       count_in;
  logic [BEAT_WIDTH-1:0]        beat_in;
  logic signed [AMP_WIDTH-1:0]  target_in;
  logic signed [AMP_WIDTH-1:0]  cur_in;
  logic signed [AMP_WIDTH-1:0]  prev_in;
  logic signed [AMP_WIDTH-1:0]  accent;
  logic [COUNT_WIDTH-1:0]       count_work;
  logic signed [AMP_WIDTH-1:0]  target_work;
  logic [BEAT_WIDTH-1:0]        beat_step;
  logic signed [SUM_WIDTH-1:0]  sum;
  logic                         sum_neg;
  logic [SUM_WIDTH-1:0]         sum_abs;
  logic [MAG_WIDTH-1:0]         quot;
  logic signed [AMP_WIDTH+2:0]  times7;
  logic signed [AMP_WIDTH+2:0]  times7_adj;
  logic signed [31:0]           result_ext;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign tick      = s_tvalid && s_tready;
  assign restart   = s_tdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_period <= PERIOD_RESET;
      meter_index <= METER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BEAT_PERIOD: beat_period <= cfg_data;
        REG_METER_INDEX: meter_index <= cfg_data[METER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Accent of the beat now sounding
  always_comb begin
    case (meter_accent(meter_index, beat_in))
      ACC_FULL:  accent = AMP_FULL;
      ACC_HALF:  accent = AMP_HALF;
      ACC_SIXTY: accent = AMP_SIXTY;
      default:   accent = '0;
    endcase
  end

  always_comb begin
    // Restart clears the run ahead of this tick
    count_in  = restart ? '0 : sample_count;
    beat_in   = restart ? '0 : beat_index;
    target_in = restart ? '0 : target_level;
    cur_in    = restart ? '0 : current_out;
    prev_in   = restart ? '0 : previous_out;

    beat_step = beat_in + BEAT_WIDTH'(1);
    if (beat_step >= meter_beats(meter_index)) begin
      beat_step = '0;
    end

    // Period match wins over the in-beat events
    count_work      = count_in;
    target_work     = target_in;
    beat_index_next = beat_in;
    if (32'(count_in) == 32'(beat_period)) begin
      count_work  = '0;
      target_work = accent;
    end else if (count_in == COUNT_WIDTH'(FLIP_COUNT)) begin
      target_work = -accent;
    end else if (count_in == COUNT_WIDTH'(RISE_COUNT)) begin
      target_work     = accent;
      beat_index_next = beat_step;
    end

    // Average of the two previous outputs and the target, toward zero
    sum     = SUM_WIDTH'(prev_in) + SUM_WIDTH'(cur_in) + SUM_WIDTH'(target_work);
    sum_neg = sum[SUM_WIDTH-1];
    sum_abs = sum_neg ? -sum : sum;
    result  = sum_neg ? -AMP_WIDTH'(quot) : AMP_WIDTH'(quot);

    // Decay the tail by seven eighths, toward zero
    times7     = ((AMP_WIDTH+3)'(target_work) <<< 3) - (AMP_WIDTH+3)'(target_work);
    times7_adj = times7[AMP_WIDTH+2] ? times7 + (AMP_WIDTH+3)'(7) : times7;
    target_level_next = (count_work > COUNT_WIDTH'(DECAY_COUNT)) ?
                        AMP_WIDTH'(times7_adj >>> 3) : target_work;

    sample_count_next = count_work + COUNT_WIDTH'(1);
    result_ext        = 32'(result);
  end

  mcg_div3 #(
    .WIDTH (MAG_WIDTH)
  ) u_div3 (
    .dividend (sum_abs[MAG_WIDTH-1:0]),
    .quotient (quot)
  );

  // Advance the run on every accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      beat_index   <= '0;
      target_level <= '0;
      current_out  <= '0;
      previous_out <= '0;
    end else if (tick) begin
      sample_count <= sample_count_next;
      beat_index   <= beat_index_next;
      target_level <= target_level_next;
      current_out  <= result;
      previous_out <= cur_in;
    end
  end

  // Output register: hold until drained
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (tick) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      m_tdata <= {5'd0, beat_in, result_ext[SAMPLE_WIDTH-1:0]};
    end
  end

`ifndef NO_ASSERTIONS
  a_beat_in_bar: assert property (@(posedge clk) disable iff (rst)
    beat_index <= 3'd5)
    else $error("beat index beyond longest bar");

  a_out_bounded: assert property (@(posedge clk) disable iff (rst)
    current_out <= AMP_FULL && current_out >= -AMP_FULL)
    else $error("click sample beyond full accent");

  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    tick |=> m_tvalid)
    else $error("accepted tick produced no result");

  a_history_shift: assert property (@(posedge clk) disable iff (rst)
    tick && !restart |=> previous_out == $past(current_out))
    else $error("filter history not shifted");
`endif

endmodule
`default_nettype wire
